### hw/rtl/balec_pkg.sv
// shared types and constants of the bounded array list engine
`default_nettype none

package balec_pkg;

   localparam int DATA_W           = 32;
   localparam int CMD_W            = 3;
   localparam int FIELD_CNT_W      = 5;
   localparam int DEFAULT_CAPACITY = 16;
   localparam int REQ_TDATA_W      = 32;
   localparam int REQ_TUSER_W      = 3;
   localparam int RSP_TDATA_W      = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 3'd0,
      CMD_PREPEND   = 3'd1,
      CMD_SORTED    = 3'd2,
      CMD_DROP_TAIL = 3'd3,
      CMD_DROP_HEAD = 3'd4,
      CMD_DELETE    = 3'd5,
      CMD_QUERY     = 3'd6
   } cmd_type;

   // first member lands in the high bits, so fields pack from accepted upward
   typedef struct packed {
      logic [FIELD_CNT_W-1:0] count_after;
      logic [FIELD_CNT_W-1:0] removed_count;
      logic                   found;
      logic                   accepted;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

`default_nettype wire

### hw/rtl/balec_mem.sv
// entry store: one write port, one read port, registered read data
`default_nettype none

module balec_mem
   import balec_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_CAPACITY,
   parameter int ADDR_W = $clog2(DEFAULT_CAPACITY)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/balec_ctrl.sv
// sequencer: decodes commands, walks the entry store, builds the result
`default_nettype none

module balec_ctrl
   import balec_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int ADDR_W   = $clog2(DEFAULT_CAPACITY),
   parameter int CNT_W    = $clog2(DEFAULT_CAPACITY + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [DATA_W-1:0] req_value,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output rsp_type                res_data,
   output logic                   mem_wr_en,
   output logic      [ADDR_W-1:0] mem_wr_addr,
   output logic      [DATA_W-1:0] mem_wr_data,
   output logic                   mem_rd_en,
   output logic      [ADDR_W-1:0] mem_rd_addr,
   input  wire logic [DATA_W-1:0] mem_rd_data
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              found_ff, found_in;
   logic              pend_ff, pend_in;
   rsp_type           res_ff, res_in;

   function automatic logic [FIELD_CNT_W-1:0] fold(input logic [CNT_W-1:0] x);
      logic [CNT_W+FIELD_CNT_W-1:0] ext;
      ext = {{FIELD_CNT_W{1'b0}}, x};
      return ext[FIELD_CNT_W-1:0];
   endfunction

   function automatic rsp_type make_rsp(input logic acc, input logic fnd,
                                        input logic [CNT_W-1:0] rem,
                                        input logic [CNT_W-1:0] cnt);
      rsp_type r;
      r.accepted      = acc;
      r.found         = fnd;
      r.removed_count = fold(rem);
      r.count_after   = fold(cnt);
      return r;
   endfunction

   always_comb begin
      logic             move;
      logic             match;
      logic             found_nxt;
      logic [CNT_W-1:0] rem_nxt;
      logic [CNT_W-1:0] wr_nxt;
      logic [CNT_W-1:0] src_nxt;
      logic [CNT_W-1:0] cnt_dec;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      val_in    = val_ff;
      dst_in    = dst_ff;
      src_in    = src_ff;
      wr_ptr_in = wr_ptr_ff;
      rem_in    = rem_ff;
      found_in  = found_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      move      = 1'b0;
      match     = 1'b0;
      found_nxt = found_ff;
      rem_nxt   = rem_ff;
      wr_nxt    = wr_ptr_ff;
      src_nxt   = CNT_W'(src_ff) + ONE_CNT;
      cnt_dec   = cnt_ff - ONE_CNT;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               val_in    = req_value;
               rem_in    = '0;
               found_in  = 1'b0;
               wr_ptr_in = '0;
               src_in    = '0;
               state_in  = ST_FINISH;
               res_in    = make_rsp(1'b0, 1'b0, '0, cnt_ff);
               case (req_cmd)
                  CMD_APPEND: begin
                     if (cnt_ff < CAP_CNT) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cnt_ff[ADDR_W-1:0];
                        mem_wr_data = req_value;
                        cnt_in      = cnt_ff + ONE_CNT;
                        res_in      = make_rsp(1'b1, 1'b0, '0, cnt_ff + ONE_CNT);
                     end
                  end
                  CMD_PREPEND, CMD_SORTED: begin
                     if (cnt_ff < CAP_CNT) begin
                        dst_in   = cnt_ff[ADDR_W-1:0];
                        state_in = ST_SHIFT;
                        if (cnt_ff != '0) begin
                           mem_rd_en   = 1'b1;
                           mem_rd_addr = cnt_dec[ADDR_W-1:0];
                           pend_in     = 1'b1;
                        end else begin
                           pend_in = 1'b0;
                        end
                     end
                  end
                  CMD_DROP_TAIL: begin
                     if (cnt_ff != '0) begin
                        cnt_in = cnt_dec;
                        res_in = make_rsp(1'b1, 1'b0, ONE_CNT, cnt_dec);
                     end
                  end
                  CMD_DROP_HEAD, CMD_DELETE, CMD_QUERY: begin
                     if (cnt_ff != '0) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        pend_in     = 1'b1;
                        state_in    = ST_SCAN;
                     end else if (req_cmd == CMD_QUERY) begin
                        res_in = make_rsp(1'b1, 1'b0, '0, cnt_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            if (!pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               mem_wr_data = val_ff;
               cnt_in      = cnt_ff + ONE_CNT;
               res_in      = make_rsp(1'b1, 1'b0, '0, cnt_ff + ONE_CNT);
               state_in    = ST_FINISH;
            end else begin
               move = (cmd_ff == CMD_PREPEND) ||
                      ($signed(mem_rd_data) > $signed(val_ff));
               mem_wr_en   = 1'b1;
               mem_wr_addr = dst_ff;
               if (move) begin
                  mem_wr_data = mem_rd_data;
                  dst_in      = dst_ff - ADDR_W'(1);
                  if (dst_ff != ADDR_W'(1)) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = dst_ff - ADDR_W'(2);
                     pend_in     = 1'b1;
                  end else begin
                     pend_in = 1'b0;
                  end
               end else begin
                  mem_wr_data = val_ff;
                  pend_in     = 1'b0;
                  cnt_in      = cnt_ff + ONE_CNT;
                  res_in      = make_rsp(1'b1, 1'b0, '0, cnt_ff + ONE_CNT);
                  state_in    = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            if (cmd_ff == CMD_DROP_HEAD) begin
               match = (src_ff == '0);
            end else begin
               match = (mem_rd_data == val_ff);
            end
            if (cmd_ff == CMD_QUERY) begin
               found_nxt = found_ff | match;
            end else if (match) begin
               rem_nxt = rem_ff + ONE_CNT;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ptr_ff[ADDR_W-1:0];
               mem_wr_data = mem_rd_data;
               wr_nxt      = wr_ptr_ff + ONE_CNT;
            end
            found_in  = found_nxt;
            rem_in    = rem_nxt;
            wr_ptr_in = wr_nxt;
            if (src_nxt < cnt_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = src_nxt[ADDR_W-1:0];
               src_in      = src_nxt[ADDR_W-1:0];
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
               if (cmd_ff == CMD_QUERY) begin
                  res_in = make_rsp(1'b1, found_nxt, '0, cnt_ff);
               end else begin
                  cnt_in = wr_nxt;
                  res_in = make_rsp(rem_nxt != '0, 1'b0, rem_nxt, wr_nxt);
               end
            end
         end

         ST_FINISH: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      dst_ff    <= dst_in;
      src_ff    <= src_in;
      wr_ptr_ff <= wr_ptr_in;
      rem_ff    <= rem_in;
      found_ff  <= found_in;
      res_ff    <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FINISH);
   assign res_data  = res_ff;

endmodule

`default_nettype wire

### hw/rtl/bounded_array_list_engine_core.sv
// Bounded array list engine: a packed list of signed 32-bit entries with a count.
//
// Input channel req_*: one transfer carries a command in req_tuser and a value in
// req_tdata. Commands append, prepend, insert in ascending order, drop the tail,
// drop the head, delete all entries equal to the value, or test membership.
// Result channel rsp_*: exactly one transfer per command, in command order,
// carrying accepted, found, removed_count and count_after.
// Append, drop tail and unused codes finish without walking the entry store;
// prepend and sorted insert move entries up one at a time, and drop head, delete
// and query walk all entries held. The block takes the next command in the cycle
// after the previous result enters the output register. The pace is set by the
// single read port and the single write port of the entry store, which moves one
// entry per cycle.
// The output register holds one result; while the receiver stalls it the
// sequencer can finish one more command and then waits with req_tready low.
// Reset empties the list and drops any pending result; the entry store itself
// needs no clearing since only positions below the count are ever read.
`default_nettype none

module bounded_array_list_engine_core
   import balec_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // value
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,  // command
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata   // accepted, found, removed_count, count_after
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic              res_valid;
   logic              slot_free;
   rsp_type           res_data;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   balec_ctrl #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_value   (req_tdata),
      .res_valid   (res_valid),
      .res_ready   (slot_free),
      .res_data    (res_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   balec_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_W){1'b0}}, rsp_data_ff};

endmodule

`default_nettype wire

### hw/rtl/balec_checker.sv
// port-level checks of the bounded array list engine and their bind
`default_nettype none

module balec_checker
   import balec_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata[RSP_W-1:0];

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a found entry only comes from an accepted query
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.found |-> rsp.accepted)
      else $error("found without accepted");

   // removals always report accepted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.removed_count != '0) |-> rsp.accepted)
      else $error("removal not reported as accepted");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind bounded_array_list_engine_core balec_checker u_balec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for the bounded array list engine core
`default_nettype none

module testbench;
   import balec_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int              LIST_CAP   = DEFAULT_CAPACITY;
   localparam int              RAND_ITEMS = 1530;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam logic [31:0]      VAL_MAX    = 32'h7fff_ffff;
   localparam logic [31:0]      VAL_MIN    = 32'h8000_0000;

   typedef struct {
      logic [CMD_W-1:0] code;
      logic [31:0]      value;
      bit               wait_idle;
   } list_op_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // value
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;  // command
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // accepted, found, removed_count, count_after

   list_op_type pending_op_q[$];
   rsp_type     expected_rsp_q[$];
   int          list_shadow[LIST_CAP];
   int          count_shadow = 0;
   int          error_count  = 0;
   int          sent_count   = 0;
   int          result_count = 0;

   bounded_array_list_engine_core #(.CAPACITY(LIST_CAP)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one command to the shadow list and returns the result it should give
   function automatic rsp_type predict_list_op(logic [CMD_W-1:0] code, logic [31:0] raw);
      int      v;
      int      i;
      int      w;
      rsp_type r;
      v = raw;
      r = '0;
      case (code)
         CMD_APPEND: begin
            if (count_shadow < LIST_CAP) begin
               list_shadow[count_shadow] = v;
               count_shadow++;
               r.accepted = 1'b1;
            end
         end
         CMD_PREPEND: begin
            if (count_shadow < LIST_CAP) begin
               for (i = count_shadow; i > 0; i--) list_shadow[i] = list_shadow[i-1];
               list_shadow[0] = v;
               count_shadow++;
               r.accepted = 1'b1;
            end
         end
         CMD_SORTED: begin
            if (count_shadow < LIST_CAP) begin
               i = count_shadow;
               while (i > 0 && list_shadow[i-1] > v) begin
                  list_shadow[i] = list_shadow[i-1];
                  i--;
               end
               list_shadow[i] = v;
               count_shadow++;
               r.accepted = 1'b1;
            end
         end
         CMD_DROP_TAIL: begin
            if (count_shadow > 0) begin
               count_shadow--;
               r.accepted      = 1'b1;
               r.removed_count = FIELD_CNT_W'(1);
            end
         end
         CMD_DROP_HEAD: begin
            if (count_shadow > 0) begin
               for (i = 0; i + 1 < count_shadow; i++) list_shadow[i] = list_shadow[i+1];
               count_shadow--;
               r.accepted      = 1'b1;
               r.removed_count = FIELD_CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            w = 0;
            for (i = 0; i < count_shadow; i++) begin
               if (list_shadow[i] == v) begin
                  r.removed_count = r.removed_count + 1'b1;
               end else begin
                  list_shadow[w] = list_shadow[i];
                  w++;
               end
            end
            count_shadow = w;
            r.accepted   = (r.removed_count != 0);
         end
         CMD_QUERY: begin
            r.accepted = 1'b1;
            for (i = 0; i < count_shadow; i++) begin
               if (list_shadow[i] == v) r.found = 1'b1;
            end
         end
         default: ;
      endcase
      r.count_after = count_shadow[FIELD_CNT_W-1:0];
      return r;
   endfunction

   // small pool so that duplicates, deletes and hits are common
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 32'($signed($urandom_range(0, 7)) - 4);
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 32'h0;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   // phase kinds: 0 grow, 1 shrink, 2 mixed
   function automatic logic [CMD_W-1:0] pick_code(int kind);
      int r;
      int ins_pct;
      int rem_pct;
      r       = $urandom_range(0, 99);
      ins_pct = (kind == 0) ? 70 : (kind == 1) ? 20 : 40;
      rem_pct = (kind == 0) ? 15 : (kind == 1) ? 60 : 35;
      if (r < 2) return CMD_UNUSED;
      if (r < 2 + ins_pct) begin
         case ($urandom_range(0, 2))
            0: return CMD_APPEND;
            1: return CMD_PREPEND;
            default: return CMD_SORTED;
         endcase
      end
      if (r < 2 + ins_pct + rem_pct) begin
         case ($urandom_range(0, 2))
            0: return CMD_DROP_TAIL;
            1: return CMD_DROP_HEAD;
            default: return CMD_DELETE;
         endcase
      end
      return CMD_QUERY;
   endfunction

   task automatic add_op(logic [CMD_W-1:0] code, logic [31:0] value, bit wait_idle = 1'b0);
      list_op_type op;
      op.code      = code;
      op.value     = value;
      op.wait_idle = wait_idle;
      pending_op_q.push_back(op);
   endtask

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(predict_list_op(req_tuser, req_tdata));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_op_q.size() != 0 &&
                         (!pending_op_q[0].wait_idle || expected_rsp_q.size() == 0)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_op_q[0].code;
               req_tdata  <= pending_op_q[0].value;
               pending_op_q.pop_front();
               if ((sent_count / 150) % 3 == 1) req_gap = 0;
               else if ($urandom_range(0, 99) < 55) req_gap = 0;
               else if ($urandom_range(0, 99) < 85) req_gap = $urandom_range(1, 4);
               else req_gap = $urandom_range(10, 40);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready generator
   int  rsp_stall      = 0;
   bit  long_hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_W-1:0]);
            result_count++;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.accepted !== want.accepted) begin
                  $display("%0t: accepted expected %0d actual %0d",
                           $time, want.accepted, got.accepted);
                  error_count++;
               end
               if (got.found !== want.found) begin
                  $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                  error_count++;
               end
               if (got.removed_count !== want.removed_count) begin
                  $display("%0t: removed_count expected %0d actual %0d",
                           $time, want.removed_count, got.removed_count);
                  error_count++;
               end
               if (got.count_after !== want.count_after) begin
                  $display("%0t: count_after expected %0d actual %0d",
                           $time, want.count_after, got.count_after);
                  error_count++;
               end
               if (rsp_tdata[RSP_TDATA_W-1:RSP_W] !== '0) begin
                  $display("%0t: padding expected 0 actual %h",
                           $time, rsp_tdata[RSP_TDATA_W-1:RSP_W]);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && result_count >= 300) begin
            long_hold_done = 1'b1;
            rsp_stall = 400;
            rsp_tready <= 1'b0;
         end else if ((result_count / 150) % 3 == 2 || $urandom_range(0, 99) < 60) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int kind;
      int len;
      int total;
      bit first;

      // empty list corner cases
      add_op(CMD_QUERY, 32'h0);
      add_op(CMD_DROP_TAIL, 32'h0);
      add_op(CMD_DROP_HEAD, VAL_MAX);
      add_op(CMD_DELETE, 32'h0);
      add_op(CMD_UNUSED, VAL_MIN);
      // value extremes, equal keys in sorted insert
      add_op(CMD_APPEND, VAL_MAX);
      add_op(CMD_APPEND, VAL_MIN);
      add_op(CMD_PREPEND, 32'h0);
      add_op(CMD_SORTED, 32'd5);
      add_op(CMD_SORTED, 32'd5);
      add_op(CMD_SORTED, 32'hffff_ffff);
      add_op(CMD_PREPEND, VAL_MAX);
      add_op(CMD_QUERY, 32'hffff_ffff);
      add_op(CMD_QUERY, 32'd7);
      add_op(CMD_QUERY, VAL_MIN);
      add_op(CMD_DELETE, 32'd5);
      add_op(CMD_DELETE, 32'd5);
      add_op(CMD_DELETE, VAL_MAX);
      add_op(CMD_UNUSED, 32'h0);
      add_op(CMD_DROP_HEAD, 32'hffff_ffff);
      add_op(CMD_DROP_TAIL, VAL_MIN);

      total = 0;
      first = 1'b1;
      while (total < RAND_ITEMS) begin
         kind = $urandom_range(0, 2);
         len  = $urandom_range(30, 80);
         for (int k = 0; k < len; k++) begin
            add_op(pick_code(kind), pick_value(),
                   k == 0 && (first || $urandom_range(0, 3) == 0));
         end
         first = 1'b0;
         total += len;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_op_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (LIST_CAP + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

`default_nettype wire
